/* design/ringff_pkg.sv */
// Shared types and codes for the ring FIFO with almost-full status.
package ringff_pkg;

  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned WORD_W     = 32;
  localparam int unsigned COUNT_W    = 4;
  localparam int unsigned ENTRIES_W  = 5;
  localparam int unsigned GAP_W      = 4;
  localparam int unsigned OUT_DATA_W = 40;

  localparam logic [ENTRIES_W-1:0] ENTRIES_RESET = 5'd16;
  localparam logic [GAP_W-1:0]     GAP_RESET     = 4'd0;

  typedef enum logic [1:0] {
    REQ_PUT       = 2'd0,
    REQ_OVERWRITE = 2'd1,
    REQ_FETCH     = 2'd2,
    REQ_PEEK      = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    ST_OK           = 2'd0,
    ST_FULL         = 2'd1,
    ST_GETTING_FULL = 2'd2,
    ST_NO_DATA      = 2'd3
  } status_t;

  typedef enum logic {
    REG_ENTRIES = 1'b0,
    REG_GAP     = 1'b1
  } reg_sel_t;

endpackage

/* design/ring_fifo_almost_full.sv */
// Ring FIFO with one slot kept empty, almost-full status and APB setup registers.
// A request is registered in the input stage, then its result in the output stage.
// Throughput: one request per cycle unless the output stalls.
// Reset (rst_n low, synchronous): indices to zero, depth to 16, gap to 0, both
// pipeline stages emptied. The slot store is not cleared.
module ring_fifo_almost_full
  import ringff_pkg::*;
#(
  parameter int unsigned DEPTH      = 16,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [WORD_W-1:0]     in_tdata,   // [31:0] data_in
  input  logic [1:0]            in_tuser,   // [1:0] req_type
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // [31:0] data_out, [35:32] fill_count
  output logic [1:0]            out_tuser,  // [1:0] status
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  localparam int unsigned IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned NW = $clog2(DEPTH + 1);

  logic [DATA_WIDTH-1:0] mem [DEPTH];
  logic [DATA_WIDTH-1:0] q_r;

  logic [ENTRIES_W-1:0] cfg_entries_r;
  logic [GAP_W-1:0]     cfg_gap_r;
  logic                 cfg_wr;
  reg_sel_t             cfg_sel;

  logic                 s1_valid_r;
  req_t                 s1_req_r;
  logic [WORD_W-1:0]    s1_data_r;

  logic [IW-1:0]        wr_idx_r, wr_idx_nxt;
  logic [IW-1:0]        rd_idx_r, rd_idx_nxt;

  logic                 out_valid_r;
  status_t              out_status_r, out_status_nxt;
  logic [COUNT_W-1:0]   out_count_r, out_count_nxt;
  logic                 out_hasdata_r, out_hasdata_nxt;

  logic                 fire;
  logic                 mem_we;
  logic [NW-1:0]        ring_n, gap_eff, wr_ext, rd_ext, wr_inc, wr_adv, rd_inc, rd_adv;
  logic [NW-1:0]        wr_new, rd_new, fill;
  logic [NW:0]          t_sum, t_wrap;
  logic [31:0]          fill32;
  logic [63:0]          din_ext, q_ext;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_sel = reg_sel_t'(paddr[2]);
  assign prdata  = (cfg_sel == REG_GAP) ? CFG_DATA_W'(cfg_gap_r) : CFG_DATA_W'(cfg_entries_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_entries_r <= ENTRIES_RESET;
      cfg_gap_r     <= GAP_RESET;
    end else if (cfg_wr) begin
      if (cfg_sel == REG_ENTRIES) begin
        cfg_entries_r <= pwdata[ENTRIES_W-1:0];
      end else begin
        cfg_gap_r <= pwdata[GAP_W-1:0];
      end
    end
  end

  assign fire      = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_req_r  <= req_t'(in_tuser);
      s1_data_r <= in_tdata;
    end
  end

  always_comb begin
    if (32'(cfg_entries_r) > 32'(DEPTH)) begin
      ring_n = NW'(DEPTH);
    end else if (cfg_entries_r < ENTRIES_W'(2)) begin
      ring_n = NW'(2);
    end else begin
      ring_n = NW'(cfg_entries_r);
    end
    if (32'(cfg_gap_r) >= 32'(ring_n)) begin
      gap_eff = ring_n - NW'(1);
    end else begin
      gap_eff = NW'(cfg_gap_r);
    end
  end

  assign wr_ext = NW'(wr_idx_r);
  assign rd_ext = NW'(rd_idx_r);
  assign wr_inc = wr_ext + NW'(1);
  assign rd_inc = rd_ext + NW'(1);
  assign wr_adv = (wr_inc == ring_n) ? '0 : wr_inc;
  assign rd_adv = (rd_inc == ring_n) ? '0 : rd_inc;
  assign t_sum  = {1'b0, wr_adv} + {1'b0, gap_eff};
  assign t_wrap = (t_sum >= {1'b0, ring_n}) ? (t_sum - {1'b0, ring_n}) : t_sum;

  always_comb begin
    wr_new          = wr_ext;
    rd_new          = rd_ext;
    out_status_nxt  = ST_OK;
    out_hasdata_nxt = 1'b0;
    mem_we          = 1'b0;
    case (s1_req_r)
      REQ_PUT: begin
        mem_we = 1'b1;
        if (wr_adv == rd_ext) begin
          out_status_nxt = ST_FULL;
        end else begin
          wr_new = wr_adv;
          if (t_wrap == {1'b0, rd_ext}) begin
            out_status_nxt = ST_GETTING_FULL;
          end
        end
      end
      REQ_OVERWRITE: begin
        mem_we = 1'b1;
        wr_new = wr_adv;
      end
      REQ_FETCH: begin
        if (wr_ext == rd_ext) begin
          out_status_nxt = ST_NO_DATA;
        end else begin
          out_hasdata_nxt = 1'b1;
          rd_new          = rd_adv;
        end
      end
      REQ_PEEK: begin
        out_hasdata_nxt = (wr_ext != rd_ext);
      end
      default: begin
        out_status_nxt = ST_OK;
      end
    endcase
    fill          = (wr_new >= rd_new) ? (wr_new - rd_new) : (wr_new + ring_n - rd_new);
    fill32        = 32'(fill);
    out_count_nxt = fill32[COUNT_W-1:0];
    wr_idx_nxt    = IW'(wr_new);
    rd_idx_nxt    = IW'(rd_new);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_idx_r <= '0;
      rd_idx_r <= '0;
    end else if (cfg_wr) begin
      wr_idx_r <= '0;
      rd_idx_r <= '0;
    end else if (fire) begin
      wr_idx_r <= wr_idx_nxt;
      rd_idx_r <= rd_idx_nxt;
    end
  end

  assign din_ext = 64'(s1_data_r);

  always_ff @(posedge clk) begin
    if (fire) begin
      if (mem_we) begin
        mem[wr_idx_r] <= din_ext[DATA_WIDTH-1:0];
      end
      q_r <= mem[rd_idx_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fire) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_status_r  <= out_status_nxt;
      out_count_r   <= out_count_nxt;
      out_hasdata_r <= out_hasdata_nxt;
    end
  end

  assign q_ext      = 64'(q_r);
  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_status_r;
  assign out_tdata  = {4'd0, out_count_r, (out_hasdata_r ? q_ext[WORD_W-1:0] : WORD_W'(0))};

endmodule

/* design/ringff_chk.sv */
// Port-level checks for the ring FIFO, bound to the top level.
module ringff_chk
  import ringff_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [OUT_DATA_W-1:0] out_tdata,
  input logic [1:0]            out_tuser
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  a_no_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == ST_NO_DATA |-> out_tdata[35:0] == 36'd0)
    else $error("no-data result carries data or count");

  a_put_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == ST_FULL || out_tuser == ST_GETTING_FULL)
      |-> out_tdata[31:0] == 32'd0 && out_tdata[35:32] != 4'd0)
    else $error("put result with data or empty count");

endmodule

bind ring_fifo_almost_full ringff_chk u_ringff_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
